// ===== rtl/ccbb_pkg.sv =====
// shared types, character codes and escape decode for the class bitmap builder
package ccbb_pkg;

  localparam int unsigned MapBits  = 256;
  localparam int unsigned WordBits = 64;
  localparam int unsigned NumWords = MapBits / WordBits;
  localparam int unsigned IdxBits  = $clog2(NumWords);

  localparam logic [7:0] ChCaret  = 8'h5E;
  localparam logic [7:0] ChDash   = 8'h2D;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChLowF   = 8'h66;
  localparam logic [7:0] ChLowN   = 8'h6E;
  localparam logic [7:0] ChLowR   = 8'h72;
  localparam logic [7:0] ChLowT   = 8'h74;
  localparam logic [7:0] ChLowV   = 8'h76;
  localparam logic [7:0] ChFf     = 8'h0C;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChVt     = 8'h0B;

  typedef logic [MapBits-1:0] map_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } item_t;

  // control between input stage, class logic and word buffer
  typedef struct packed {
    logic fire;
    logic load;
  } step_t;

  function automatic logic [7:0] unescape(input logic [7:0] b);
    logic [7:0] r;
    unique case (b)
      ChLowF:  r = ChFf;
      ChLowN:  r = ChLf;
      ChLowR:  r = ChCr;
      ChLowT:  r = ChTab;
      ChLowV:  r = ChVt;
      default: r = b;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/ccbb_in_stage.sv =====
// input register for one class byte
module ccbb_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  ccbb_pkg::item_t item_i,
  input  logic           fire_i,
  output logic           valid_o,
  output ccbb_pkg::item_t item_o
);

  logic            valid_q, valid_d;
  ccbb_pkg::item_t item_q;

  // slot frees when its byte is processed this cycle
  assign ready_o = !valid_q || fire_i;
  assign valid_d = (valid_i && ready_o) || (valid_q && !fire_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== rtl/ccbb_class_logic.sv =====
// class parser state and membership map update
module ccbb_class_logic (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fire_i,
  input  ccbb_pkg::item_t item_i,
  output ccbb_pkg::map_t  map_o
);

  ccbb_pkg::map_t map_q, map_d, hit;
  logic       neg_q, neg_d;
  logic       start_q, start_d;
  logic [7:0] rs_q, rs_d;
  logic       sv_q, sv_d;
  logic       esc_q, esc_d;
  logic       rp_q, rp_d;
  logic       take;
  logic [7:0] c, lo, hi;
  logic [7:0] b;
  logic       last;

  assign b    = item_i.ch;
  assign last = item_i.last;

  // one compare pair per map bit
  always_comb begin
    for (int k = 0; k < ccbb_pkg::MapBits; k++) begin
      hit[k] = (8'(k) >= lo) && (8'(k) <= hi);
    end
  end

  always_comb begin
    map_d = map_q;
    neg_d = neg_q;
    rs_d  = rs_q;
    sv_d  = sv_q;
    esc_d = esc_q;
    rp_d  = rp_q;
    take  = 1'b0;
    c     = b;
    if (esc_q) begin
      esc_d = 1'b0;
      take  = 1'b1;
      c     = ccbb_pkg::unescape(b);
    end else if (start_q && !neg_q && b == ccbb_pkg::ChCaret) begin
      neg_d = 1'b1;
      map_d = '1;
    end else if (b == ccbb_pkg::ChBslash) begin
      if (last) begin
        take = 1'b1;
      end else begin
        esc_d = 1'b1;
      end
    end else if (b == ccbb_pkg::ChDash && !rp_q && !start_q && sv_q && !last) begin
      rp_d = 1'b1;
    end else begin
      take = 1'b1;
    end

    lo = rp_q ? rs_q : c;
    hi = c;
    if (take) begin
      map_d = neg_q ? (map_q & ~hit) : (map_q | hit);
      if (rp_q) begin
        rp_d = 1'b0;
      end else begin
        rs_d = c;
        sv_d = 1'b1;
      end
    end
    start_d = start_q && neg_d && b == ccbb_pkg::ChCaret && !sv_d && !esc_d && !rp_d;
  end

  assign map_o = map_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q   <= '0;
      neg_q   <= 1'b0;
      start_q <= 1'b1;
      rs_q    <= '0;
      sv_q    <= 1'b0;
      esc_q   <= 1'b0;
      rp_q    <= 1'b0;
    end else if (fire_i) begin
      if (last) begin
        map_q   <= '0;
        neg_q   <= 1'b0;
        start_q <= 1'b1;
        rs_q    <= '0;
        sv_q    <= 1'b0;
        esc_q   <= 1'b0;
        rp_q    <= 1'b0;
      end else begin
        map_q   <= map_d;
        neg_q   <= neg_d;
        start_q <= start_d;
        rs_q    <= rs_d;
        sv_q    <= sv_d;
        esc_q   <= esc_d;
        rp_q    <= rp_d;
      end
    end
  end

endmodule

// ===== rtl/ccbb_word_out.sv =====
// result register holding a finished map, sent as four word beats
module ccbb_word_out (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ccbb_pkg::step_t               step_i,
  input  ccbb_pkg::map_t                map_i,
  output logic                          free_o,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic [ccbb_pkg::WordBits-1:0] word_o,
  output logic [ccbb_pkg::IdxBits-1:0]  idx_o,
  output logic                          last_o
);

  ccbb_pkg::map_t                words_q;
  logic [ccbb_pkg::IdxBits-1:0]  idx_q, idx_d;
  logic                          busy_q, busy_d;
  logic                          beat, final_beat;

  assign beat       = busy_q && ready_i;
  assign final_beat = beat && (idx_q == ccbb_pkg::IdxBits'(ccbb_pkg::NumWords - 1));
  assign free_o     = !busy_q || final_beat;

  always_comb begin
    idx_d  = idx_q;
    busy_d = busy_q;
    if (beat) begin
      idx_d  = idx_q + 1'b1;
      busy_d = !final_beat;
    end
    if (step_i.load) begin
      idx_d  = '0;
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      idx_q  <= idx_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i.load) begin
      words_q <= map_i;
    end
  end

  assign valid_o = busy_q;
  assign word_o  = words_q[idx_q*ccbb_pkg::WordBits +: ccbb_pkg::WordBits];
  assign idx_o   = idx_q;
  assign last_o  = (idx_q == ccbb_pkg::IdxBits'(ccbb_pkg::NumWords - 1));

endmodule

// ===== rtl/char_class_bitmap_builder_core.sv =====
// top level of the character class bitmap builder
//
//   channel  dir  beat content
//   s_axis   in   tdata[7:0] class byte, tlast end of class body
//   m_axis   out  tdata[63:0] map word, tuser word index, tlast final word
//
// one class byte is taken per cycle unless a final byte waits for the word
// buffer; a byte is held in the input register and is folded into the map
// by the 256-wide range compare; a final byte loads the finished map into
// the word buffer and yields four output beats, so a final byte waits while
// the buffer still sends a map
// output stalls back up only through that buffer; plain bytes keep flowing
// reset is asynchronous and clears parser state and both valid flags
module char_class_bitmap_builder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] class_byte
  input  logic        s_axis_tlast_i,   // end_of_class
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // [63:0] map_word
  output logic [1:0]  m_axis_tuser_o,   // [1:0] word_index
  output logic        m_axis_tlast_o    // final_word
);

  ccbb_pkg::item_t in_item, cur_item;
  ccbb_pkg::step_t step;
  ccbb_pkg::map_t  map_next;
  logic            cur_valid;
  logic            out_free;

  assign in_item.ch   = s_axis_tdata_i;
  assign in_item.last = s_axis_tlast_i;

  // a final byte needs the word buffer free (or draining this cycle)
  assign step.fire = cur_valid && (!cur_item.last || out_free);
  assign step.load = step.fire && cur_item.last;

  ccbb_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .item_i  (in_item),
    .fire_i  (step.fire),
    .valid_o (cur_valid),
    .item_o  (cur_item)
  );

  ccbb_class_logic u_class (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (step.fire),
    .item_i (cur_item),
    .map_o  (map_next)
  );

  ccbb_word_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .map_i   (map_next),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .word_o  (m_axis_tdata_o),
    .idx_o   (m_axis_tuser_o),
    .last_o  (m_axis_tlast_o)
  );

endmodule

// ===== tb/sv/tb_char_class_bitmap_builder_core.sv =====
// self-checking testbench for char_class_bitmap_builder_core
module tb_char_class_bitmap_builder_core;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned RandomBytes = 150;
  localparam int unsigned BackToBackBytes = 80;

  typedef struct packed {
    logic [63:0] word;
    logic [1:0]  idx;
    logic        last;
  } map_beat_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i;
  logic        s_axis_tlast_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [63:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  char_class_bitmap_builder_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // predicted class state
  ccbb_pkg::map_t class_map;
  logic           negated_q;
  logic           at_start_q;
  logic [7:0]     range_lo_q;
  logic           start_valid_q;
  logic [1:0]     escape_q;
  logic           range_pend_q;

  map_beat_t  map_words_due[$];
  logic [7:0] body_q[$];
  map_beat_t  got_beat;
  map_beat_t  want_beat;
  int         fail_count;
  int         bytes_sent;
  int         cycle_count;
  bit         gaps_on;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
    fail_count++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  task automatic clear_class();
    class_map     = '0;
    negated_q     = 1'b0;
    at_start_q    = 1'b1;
    range_lo_q    = 8'h00;
    start_valid_q = 1'b0;
    escape_q      = 2'd0;
    range_pend_q  = 1'b0;
  endtask

  task automatic mark_chars(input logic [7:0] lo, input logic [7:0] hi);
    for (int k = 0; k < 256; k++) begin
      if (8'(k) >= lo && 8'(k) <= hi) class_map[k] = !negated_q;
    end
  endtask

  task automatic take_char(input logic [7:0] c);
    if (range_pend_q) begin
      mark_chars(range_lo_q, c);
      range_pend_q = 1'b0;
    end else begin
      mark_chars(c, c);
      range_lo_q    = c;
      start_valid_q = 1'b1;
    end
  endtask

  // fold one accepted byte into the predicted map; a final byte queues four words
  task automatic fold_class_byte(input logic [7:0] b, input logic last);
    logic [7:0] c;
    if (escape_q != 2'd0) begin
      escape_q = 2'd0;
      case (b)
        ccbb_pkg::ChLowF: c = ccbb_pkg::ChFf;
        ccbb_pkg::ChLowN: c = ccbb_pkg::ChLf;
        ccbb_pkg::ChLowR: c = ccbb_pkg::ChCr;
        ccbb_pkg::ChLowT: c = ccbb_pkg::ChTab;
        ccbb_pkg::ChLowV: c = ccbb_pkg::ChVt;
        default:          c = b;
      endcase
      take_char(c);
    end else if (at_start_q && !negated_q && b == ccbb_pkg::ChCaret) begin
      negated_q = 1'b1;
      class_map = '1;
    end else if (b == ccbb_pkg::ChBslash) begin
      if (last) take_char(b);
      else escape_q = 2'd1;
    end else if (b == ccbb_pkg::ChDash && !range_pend_q && !at_start_q &&
                 start_valid_q && !last) begin
      range_pend_q = 1'b1;
    end else begin
      take_char(b);
    end
    // a negating caret keeps the body at its start for a leading dash
    if (!(at_start_q && negated_q && b == ccbb_pkg::ChCaret && !start_valid_q &&
          escape_q == 2'd0 && !range_pend_q))
      at_start_q = 1'b0;
    if (last) begin
      for (int w = 0; w < 4; w++)
        map_words_due.push_back(map_beat_t'{word: class_map[w*64 +: 64], idx: w[1:0],
                                            last: (w == 3)});
      clear_class();
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    fold_class_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_body();
    for (int i = 0; i < body_q.size(); i++)
      send_byte(body_q[i], i == body_q.size() - 1);
  endtask

  task automatic send_text(input string s);
    body_q.delete();
    for (int i = 0; i < s.len(); i++) body_q.push_back(s[i]);
    send_body();
  endtask

  function automatic logic [7:0] rand_char();
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(8'h20, 8'h7E));
  endfunction

  function automatic logic [7:0] rand_escape();
    case ($urandom_range(0, 6))
      0:       return ccbb_pkg::ChLowF;
      1:       return ccbb_pkg::ChLowN;
      2:       return ccbb_pkg::ChLowR;
      3:       return ccbb_pkg::ChLowT;
      4:       return ccbb_pkg::ChLowV;
      5:       return ccbb_pkg::ChBslash;
      default: return rand_char();
    endcase
  endfunction

  // mostly well-formed bodies built from tokens, some pure noise
  task automatic build_class_body(input int max_tokens);
    int ntok;
    body_q.delete();
    ntok = $urandom_range(1, max_tokens);
    if ($urandom_range(0, 4) == 0) begin
      for (int i = 0; i < ntok; i++) begin
        case ($urandom_range(0, 4))
          0:       body_q.push_back(ccbb_pkg::ChCaret);
          1:       body_q.push_back(ccbb_pkg::ChDash);
          2:       body_q.push_back(ccbb_pkg::ChBslash);
          default: body_q.push_back(8'($urandom_range(0, 255)));
        endcase
      end
    end else begin
      if ($urandom_range(0, 3) == 0) body_q.push_back(ccbb_pkg::ChCaret);
      for (int i = 0; i < ntok; i++) begin
        case ($urandom_range(0, 9))
          0, 1, 2: body_q.push_back(rand_char());
          3, 4: begin
            body_q.push_back(rand_char());
            body_q.push_back(ccbb_pkg::ChDash);
            body_q.push_back(rand_char());
          end
          5: begin
            body_q.push_back(ccbb_pkg::ChBslash);
            body_q.push_back(rand_escape());
          end
          6: body_q.push_back(ccbb_pkg::ChDash);
          7: body_q.push_back(ccbb_pkg::ChCaret);
          8: begin
            body_q.push_back(rand_char());
            body_q.push_back(ccbb_pkg::ChDash);
            body_q.push_back(ccbb_pkg::ChBslash);
            body_q.push_back(rand_escape());
          end
          default: body_q.push_back(8'($urandom_range(0, 255)));
        endcase
      end
    end
  endtask

  task automatic test_directed_classes();
    send_text("^");                  // lone caret gives all ones
    send_text("^-a");                // negation, dash right after caret is leading
    send_text("a^-c-e");             // later caret literal, range chaining
    send_text("z-a-");               // empty range, trailing dash
    send_text("-!--");               // leading dash, dash closing a range
    body_q = '{8'h00, ccbb_pkg::ChDash, 8'hFF};
    send_body();                     // full byte range
    send_text("\\f\\r\\t\\v\\n\\q\\");  // control escapes, other escape, trailing backslash
    send_text("0-\\");               // trailing backslash closes a pending range
  endtask

  task automatic test_random_classes();
    int stop_at;
    stop_at = bytes_sent + RandomBytes;
    while (bytes_sent < stop_at) begin
      build_class_body($urandom_range(0, 9) == 0 ? 12 : 4);
      send_body();
    end
  endtask

  task automatic test_back_to_back();
    int stop_at;
    gaps_on = 1'b0;
    stop_at = bytes_sent + BackToBackBytes;
    while (bytes_sent < stop_at) begin
      build_class_body(2);
      send_body();
    end
    gaps_on = 1'b1;
  endtask

  // receiver stall pattern
  initial begin
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      int hold;
      hold = pick_gap();
      if (hold > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  // compare each output beat with the oldest predicted map word
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got_beat = '{word: m_axis_tdata_o, idx: m_axis_tuser_o, last: m_axis_tlast_o};
      if (map_words_due.size() == 0) begin
        flag_mismatch("beat with no map word due", got_beat.word, '0);
      end else begin
        want_beat = map_words_due.pop_front();
        if (got_beat.word !== want_beat.word)
          flag_mismatch("map_word", got_beat.word, want_beat.word);
        if (got_beat.idx !== want_beat.idx)
          flag_mismatch("word_index", 64'(got_beat.idx), 64'(want_beat.idx));
        if (got_beat.last !== want_beat.last)
          flag_mismatch("final_word", 64'(got_beat.last), 64'(want_beat.last));
      end
    end
  end

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = 8'h00;
    s_axis_tlast_i  = 1'b0;
    bytes_sent      = 0;
    gaps_on         = 1'b1;
    clear_class();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_classes();
    test_random_classes();
    test_back_to_back();
    test_random_classes();

    s_axis_tvalid_i <= 1'b0;
    while (map_words_due.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
